FILE: hw/rtl/assert_macros.svh
// assertion macros used by the wind rotation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GEW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GEW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gew_pkg.sv
// types, constants and helper functions for the wind rotation block
package gew_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SIN_TRUE_LAT     = 2'd0;
	localparam logic [1:0] REG_CENTER_LON       = 2'd1;
	localparam logic [1:0] REG_MISSING_CODE     = 2'd2;
	localparam logic [1:0] REG_UNAVAILABLE_CODE = 2'd3;

	// register reset values
	localparam logic signed [15:0] RST_SIN_TRUE_LAT     = 16'sd20398;
	localparam logic signed [24:0] RST_CENTER_LON       = -25'sd6389760;
	localparam logic signed [15:0] RST_MISSING_CODE     = 16'sh8000;
	localparam logic signed [15:0] RST_UNAVAILABLE_CODE = 16'sh8001;

	// angle divide: n / 180 done as (n >> 2) / 45, eight quotient bits per stage
	localparam int DIVISOR     = 45;
	localparam int DIV_DIGITS  = 8;
	localparam int DIV_STAGES  = 5;
	localparam int DIV_W       = DIV_DIGITS * DIV_STAGES;
	localparam int ROUND_HALF  = 90;

	// item queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// cordic constants
	localparam int INV_GAIN    = 39796;
	localparam int ATAN_LEN    = 24;
	localparam int XY_W        = 34;
	localparam int R_W         = 33;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// configuration seen by the front
	typedef struct packed {
		logic signed [15:0] sin_true_lat;
		logic signed [24:0] center_lon;
		logic signed [15:0] missing_code;
		logic signed [15:0] unavailable_code;
	} gew_cfg_t;

	// one item in the queue: raw wind, sentinel flag and rotation angle
	typedef struct packed {
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic               flag;
		logic [31:0]        z;
	} gew_item_t;

	// result of one radix-2^8 digit of the divide
	typedef struct packed {
		logic [5:0] rem;
		logic [7:0] qbits;
	} gew_div_t;

	// eight restoring steps of the divide by 45
	function automatic gew_div_t div_digit8(logic [5:0] rem_in, logic [7:0] bits);
		gew_div_t   res;
		logic [6:0] t;
		logic [5:0] rem;
		rem = rem_in;
		res.qbits = '0;
		for (int i = DIV_DIGITS - 1; i >= 0; i--) begin
			t = {rem, bits[i]};
			if (t >= 7'(DIVISOR)) begin
				res.qbits[i] = 1'b1;
				t = t - 7'(DIVISOR);
			end
			rem = t[5:0];
		end
		res.rem = rem;
		return res;
	endfunction

	// round Q10.24 to Q8.8 and saturate
	function automatic logic signed [15:0] sat_q88(logic signed [XY_W-1:0] val);
		logic signed [XY_W-1:0] sh;
		sh = (val + XY_W'(32768)) >>> 16;
		if (sh > XY_W'(32767))
			return 16'sh7FFF;
		else if (sh < -XY_W'(32768))
			return 16'sh8000;
		else
			return sh[15:0];
	endfunction

endpackage

FILE: hw/rtl/gew_front.sv
// front end: sentinel check and rotation angle from longitude
module gew_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  u_grid,
	input  logic signed [15:0]  v_grid,
	input  logic signed [24:0]  cell_lon,
	input  gew_pkg::gew_cfg_t   cfg,
	input  logic                q_full,
	output logic                push,
	output gew_pkg::gew_item_t  push_item
);

	localparam int NS = gew_pkg::DIV_STAGES;
	localparam int DW = gew_pkg::DIV_W;
	localparam int DD = gew_pkg::DIV_DIGITS;

	logic en;

	logic                vld_s1, vld_s2, vld_s3;
	logic signed [15:0]  uw_s1, uw_s2, uw_s3;
	logic signed [15:0]  vw_s1, vw_s2, vw_s3;
	logic                flag_s1, flag_s2, flag_s3;
	logic signed [25:0]  d_s1;
	logic signed [41:0]  p_s2;
	logic                neg_s3;
	logic [DW-1:0]       num_s3;

	logic [40:0]         mag;
	logic [40:0]         rnd;

	// divide stage registers, one slot per stage
	logic                div_vld_s  [NS];
	logic signed [15:0]  div_uw_s   [NS];
	logic signed [15:0]  div_vw_s   [NS];
	logic                div_flag_s [NS];
	logic                div_neg_s  [NS];
	logic [5:0]          div_rem_s  [NS];
	logic [DW-1:0]       div_num_s  [NS];
	logic [DW-1:0]       div_quo_s  [NS];

	logic [31:0]         q32;

	// whole front moves unless a finished item cannot enter the queue
	assign en       = !(div_vld_s[NS-1] && q_full);
	assign in_stall = !en;

	// stage 1: sentinel test and longitude difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uw_s1   <= u_grid;
			vw_s1   <= v_grid;
			flag_s1 <= (u_grid == cfg.missing_code) || (u_grid == cfg.unavailable_code) ||
			           (v_grid == cfg.missing_code) || (v_grid == cfg.unavailable_code);
			d_s1    <= 26'(cell_lon) - 26'(cfg.center_lon);
		end
	end

	// stage 2: scale by sine of true latitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uw_s2   <= uw_s1;
			vw_s2   <= vw_s1;
			flag_s2 <= flag_s1;
			p_s2    <= 42'(cfg.sin_true_lat) * 42'(d_s1);
		end
	end

	// stage 3: magnitude plus half divisor, then drop the factor of four
	assign mag = p_s2[41] ? 41'(-p_s2) : 41'(p_s2);
	assign rnd = mag + 41'(gew_pkg::ROUND_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uw_s3   <= uw_s2;
			vw_s3   <= vw_s2;
			flag_s3 <= flag_s2;
			neg_s3  <= p_s2[41];
			num_s3  <= DW'(rnd[40:2]);
		end
	end

	// divide by 45, one byte of quotient per stage
	for (genvar k = 0; k < NS; k++) begin : g_div
		logic                vld_in, flag_in, neg_in;
		logic signed [15:0]  uw_in, vw_in;
		logic [5:0]          rem_in;
		logic [DW-1:0]       num_in, quo_in;
		gew_pkg::gew_div_t   dig;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s3;
			assign flag_in = flag_s3;
			assign neg_in  = neg_s3;
			assign uw_in   = uw_s3;
			assign vw_in   = vw_s3;
			assign rem_in  = '0;
			assign num_in  = num_s3;
			assign quo_in  = '0;
		end else begin : g_next
			assign vld_in  = div_vld_s[k-1];
			assign flag_in = div_flag_s[k-1];
			assign neg_in  = div_neg_s[k-1];
			assign uw_in   = div_uw_s[k-1];
			assign vw_in   = div_vw_s[k-1];
			assign rem_in  = div_rem_s[k-1];
			assign num_in  = div_num_s[k-1];
			assign quo_in  = div_quo_s[k-1];
		end

		assign dig = gew_pkg::div_digit8(rem_in, num_in[DW-1 -: DD]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (en) begin
				div_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_flag_s[k] <= flag_in;
				div_neg_s[k]  <= neg_in;
				div_uw_s[k]   <= uw_in;
				div_vw_s[k]   <= vw_in;
				div_rem_s[k]  <= dig.rem;
				div_num_s[k]  <= {num_in[DW-DD-1:0], {DD{1'b0}}};
				div_quo_s[k]  <= {quo_in[DW-DD-1:0], dig.qbits};
			end
		end
	end

	// applied angle is minus the phase, wrapped to one turn
	assign q32            = div_quo_s[NS-1][31:0];
	assign push           = div_vld_s[NS-1] && !q_full;
	assign push_item.u    = div_uw_s[NS-1];
	assign push_item.v    = div_vw_s[NS-1];
	assign push_item.flag = div_flag_s[NS-1];
	assign push_item.z    = div_neg_s[NS-1] ? q32 : (32'd0 - q32);

endmodule

FILE: hw/rtl/gew_queue.sv
// short item queue between front and back
`include "assert_macros.svh"

module gew_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gew_pkg::gew_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output gew_pkg::gew_item_t  pop_item,
	output logic                empty
);

	localparam int DEPTH = gew_pkg::QUEUE_DEPTH;
	localparam int PW    = gew_pkg::QPTR_W;

	gew_pkg::gew_item_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q, rd_q;
	logic [PW:0]        count_q;

	assign full     = (count_q == (PW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	`GEW_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full, "push into full queue")
	`GEW_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from empty queue")
	`GEW_ASSERT_NXT(a_count_track, clk, arst_n, 1'b1,
		count_q == $past(count_q) + (PW+1)'($past(push)) - (PW+1)'($past(pop)),
		"fill count out of step")

endmodule

FILE: hw/rtl/gew_back.sv
// back end: quadrant fold, pipelined cordic rotation, rounding and output register
module gew_back #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  gew_pkg::gew_item_t  q_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  u_earth,
	output logic signed [15:0]  v_earth,
	output logic                passed_through
);

	// stage count is limited by the length of the angle table
	localparam int N  = (CORDIC_STAGES > gew_pkg::ATAN_LEN) ? gew_pkg::ATAN_LEN : CORDIC_STAGES;
	localparam int XW = gew_pkg::XY_W;
	localparam int RW = gew_pkg::R_W;

	logic en;

	logic                vld_s  [N+1];
	logic                flag_s [N+1];
	logic signed [15:0]  uw_s   [N+1];
	logic signed [15:0]  vw_s   [N+1];
	logic signed [XW-1:0] x_s   [N+1];
	logic signed [XW-1:0] y_s   [N+1];
	logic signed [RW-1:0] r_s   [N+1];

	logic                out_valid_q;

	logic [1:0]          top;
	logic                fold;
	logic signed [16:0]  un, vn;
	logic signed [16:0]  kinv;
	logic [31:0]         zf;

	// back moves unless the output holds an item nobody takes
	assign en  = !(out_valid_q && out_stall);
	assign pop = en && !q_empty;

	// quadrant fold and inverse gain prescale
	always_comb begin
		top  = q_item.z[31:30];
		fold = top inside {2'b01, 2'b10};
		un   = fold ? -17'(q_item.u) : 17'(q_item.u);
		vn   = fold ? -17'(q_item.v) : 17'(q_item.v);
		kinv = 17'(gew_pkg::INV_GAIN);
		zf   = q_item.z + (fold ? 32'h8000_0000 : 32'h0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s[0] <= q_item.flag;
			uw_s[0]   <= q_item.u;
			vw_s[0]   <= q_item.v;
			x_s[0]    <= XW'(un) * XW'(kinv);
			y_s[0]    <= XW'(vn) * XW'(kinv);
			r_s[0]    <= RW'($signed(zf));
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [XW-1:0] xs, ys;
		logic signed [RW-1:0] at;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = RW'(gew_pkg::ATAN_TURNS[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flag_s[i+1] <= flag_s[i];
				uw_s[i+1]   <= uw_s[i];
				vw_s[i+1]   <= vw_s[i];
				if (!r_s[i][RW-1]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					r_s[i+1] <= r_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					r_s[i+1] <= r_s[i] + at;
				end
			end
		end
	end

	// output register: round and saturate, or copy on a sentinel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			passed_through <= flag_s[N];
			if (flag_s[N]) begin
				u_earth <= uw_s[N];
				v_earth <= vw_s[N];
			end else begin
				u_earth <= gew_pkg::sat_q88(x_s[N]);
				v_earth <= gew_pkg::sat_q88(y_s[N]);
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/grid_to_earth_wind_rotation.sv
// top level: register file, front end, item queue and cordic back end
//
//  channel | handshake                    | payload
//  --------+------------------------------+---------------------------------------
//  in      | in_valid / in_stall          | u_grid, v_grid, cell_lon
//  out     | out_valid / out_stall        | u_earth, v_earth, passed_through
//  cfg     | cfg_valid / cfg_ready (=1)   | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; every stage is pipelined
// pipeline: 8 front stages (difference, multiply, round, five divide stages),
//   one queue slot, then CORDIC_STAGES (at most 24) + 2 back stages including the output register
// front and back stall separately; the four-entry queue takes up the slip
// in_stall rises only when the queue is full and the front holds a finished item
// reset clears all valid bits and loads the register defaults; no clearing pass
module grid_to_earth_wind_rotation #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] u_grid,
	input  logic signed [15:0] v_grid,
	input  logic signed [24:0] cell_lon,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] u_earth,
	output logic signed [15:0] v_earth,
	output logic               passed_through,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [24:0]        cfg_data
);

	gew_pkg::gew_cfg_t  cfg_q;
	gew_pkg::gew_item_t push_item, pop_item;
	logic               push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sin_true_lat     <= gew_pkg::RST_SIN_TRUE_LAT;
			cfg_q.center_lon       <= gew_pkg::RST_CENTER_LON;
			cfg_q.missing_code     <= gew_pkg::RST_MISSING_CODE;
			cfg_q.unavailable_code <= gew_pkg::RST_UNAVAILABLE_CODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gew_pkg::REG_SIN_TRUE_LAT:     cfg_q.sin_true_lat     <= cfg_data[15:0];
				gew_pkg::REG_CENTER_LON:       cfg_q.center_lon       <= cfg_data;
				gew_pkg::REG_MISSING_CODE:     cfg_q.missing_code     <= cfg_data[15:0];
				gew_pkg::REG_UNAVAILABLE_CODE: cfg_q.unavailable_code <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// angle and sentinel front end
	gew_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.u_grid    (u_grid),
		.v_grid    (v_grid),
		.cell_lon  (cell_lon),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	gew_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	// rotation back end
	gew_back #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_item         (pop_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.u_earth        (u_earth),
		.v_earth        (v_earth),
		.passed_through (passed_through)
	);

endmodule
